// ----- design/cebl_pkg.sv -----
// Package for the CBOR envelope body locator: phase codes, roles and helpers.
// Used by the controller, the datapath and the top level.
package cebl_pkg;
    localparam int MaxMessageLen = 65536;
    localparam int MaxNestDepth  = 32;
    localparam int DigestBytes   = 32;

    localparam logic [1:0] ROLE_HEADER = 2'd0;
    localparam logic [1:0] ROLE_DIGEST = 2'd1;
    localparam logic [1:0] ROLE_BODY   = 2'd2;
    localparam logic [1:0] ROLE_ERROR  = 2'd3;

    localparam logic [3:0] PH_MAP    = 4'd0;
    localparam logic [3:0] PH_K1     = 4'd1;
    localparam logic [3:0] PH_K3     = 4'd2;
    localparam logic [3:0] PH_K2     = 4'd3;
    localparam logic [3:0] PH_VER    = 4'd4;
    localparam logic [3:0] PH_K3B    = 4'd5;
    localparam logic [3:0] PH_DLEN   = 4'd6;
    localparam logic [3:0] PH_DIGEST = 4'd7;
    localparam logic [3:0] PH_K4     = 4'd8;
    localparam logic [3:0] PH_BODY   = 4'd9;
    localparam logic [3:0] PH_DONE   = 4'd10;

    localparam logic [2:0] MT_UINT  = 3'd0;
    localparam logic [2:0] MT_NINT  = 3'd1;
    localparam logic [2:0] MT_BSTR  = 3'd2;
    localparam logic [2:0] MT_TSTR  = 3'd3;
    localparam logic [2:0] MT_ARRAY = 3'd4;
    localparam logic [2:0] MT_MAP   = 3'd5;
    localparam logic [2:0] MT_TAG   = 3'd6;
    localparam logic [2:0] MT_SIMPLE = 3'd7;

    localparam logic [4:0] AI_ONE   = 5'd24;
    localparam logic [4:0] AI_TWO   = 5'd25;
    localparam logic [4:0] AI_FOUR  = 5'd26;
    localparam logic [4:0] AI_EIGHT = 5'd27;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;       // Return the datapath registers that have a reset to the reset value.
        logic acc_load;    // Start an argument: clear accumulator, load count.
        logic acc_shift;   // Shift one byte into the argument.
        logic pay_load_arg;// Payload count takes the finished argument.
        logic pay_load_dig;// Payload count takes the digest length.
        logic pay_load_ext;// Payload count takes the simple-value extra size.
        logic pay_dec;     // Count one payload byte.
        logic ver_load;    // Keep the version.
        logic start_load;  // Keep the body start position.
        logic pos_inc;     // Count the accepted byte.
        logic push;        // Open a container.
        logic pop_dec;     // Decrement the top count.
        logic pop_level;   // Close the top container.
        logic major_load;  // Keep the body major type.
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic        arg_left_zero;
        logic        arg_last;      // One argument byte remains.
        logic [63:0] arg_value;     // Argument including the current byte.
        logic        pay_zero;
        logic        pay_one;
        logic        pos_full;
        logic        level_zero;
        logic        level_over;    // Nesting level above the depth limit.
        logic        top_le_one;    // Top count is at most one.
        logic [2:0]  body_major;
    } t_status;

    function automatic logic [3:0] extra_bytes(input logic [4:0] ai);
        unique case (ai)
            AI_ONE:   extra_bytes = 4'd1;
            AI_TWO:   extra_bytes = 4'd2;
            AI_FOUR:  extra_bytes = 4'd4;
            AI_EIGHT: extra_bytes = 4'd8;
            default:  extra_bytes = 4'd0;
        endcase
    endfunction

    function automatic logic [2:0] want_major(input logic [3:0] ph);
        unique case (ph)
            PH_MAP:  want_major = MT_MAP;
            PH_DLEN: want_major = MT_BSTR;
            default: want_major = MT_UINT;
        endcase
    endfunction
endpackage

// ----- design/cebl_datapath.sv -----
// Datapath of the envelope locator: argument, payload, position and count stack.
// Depends on cebl_pkg; driven by cebl_ctrl through t_cmd.
module cebl_datapath #(
    parameter int MAX_MESSAGE_LEN = cebl_pkg::MaxMessageLen,
    parameter int MAX_NEST_DEPTH  = cebl_pkg::MaxNestDepth,
    parameter int DIGEST_BYTES    = cebl_pkg::DigestBytes
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_byte,
    input  cebl_pkg::t_cmd    i_cmd,
    output cebl_pkg::t_status o_status,
    output logic [31:0]       o_version,
    output logic [16:0]       o_offset,
    output logic [16:0]       o_length
);
    import cebl_pkg::*;

    localparam int LvlW  = $clog2(MAX_NEST_DEPTH + 2);
    localparam int Depth = MAX_NEST_DEPTH;
    localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int PosW  = $clog2(MAX_MESSAGE_LEN + 1);
    localparam int CntW  = $clog2(2 * (MAX_MESSAGE_LEN + 1) + 1);
    localparam logic [63:0] Lim = 64'(MAX_MESSAGE_LEN + 1);

    logic [63:0]     r_acc, n_acc;
    logic [3:0]      r_left;
    logic [63:0]     r_pay;
    logic [PosW-1:0] r_pos;
    logic [31:0]     r_ver;
    logic [PosW-1:0] r_start;
    logic [LvlW-1:0] r_level;
    logic [2:0]      r_major;
    logic [CntW-1:0] r_stack [Depth];
    logic [CntW-1:0] r_top;
    logic [63:0]     w_val;
    logic [CntW-1:0] w_push;
    logic [IdxW-1:0] w_wr_idx;
    logic [IdxW-1:0] w_rd_idx;

    assign n_acc    = {r_acc[55:0], i_byte};
    assign w_val    = (r_left == 4'd0) ? 64'(i_byte[4:0]) : n_acc;
    assign w_wr_idx = IdxW'(r_level - LvlW'(1));
    assign w_rd_idx = IdxW'(r_level - LvlW'(2));

    always_comb begin
        logic [63:0] w_arg;
        logic [2:0]  w_mt;
        w_arg = w_val;
        w_mt  = (r_left == 4'd0) ? i_byte[7:5] : r_major;
        if (w_arg > Lim) begin
            w_arg = Lim;
        end
        if (w_mt == MT_MAP) begin
            w_push = CntW'(w_arg) << 1;
        end else if (w_mt == MT_ARRAY) begin
            w_push = CntW'(w_arg);
        end else begin
            w_push = CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_acc   <= '0;
            r_left  <= '0;
            r_pay   <= '0;
            r_pos   <= '0;
            r_ver   <= '0;
            r_start <= '0;
            r_level <= '0;
            r_major <= '0;
        end else begin
            if (i_cmd.acc_load) begin
                r_acc  <= '0;
                r_left <= extra_bytes(i_byte[4:0]);
            end else if (i_cmd.acc_shift) begin
                r_acc  <= n_acc;
                r_left <= r_left - 4'd1;
            end
            if (i_cmd.pay_load_arg) begin
                r_pay <= w_val;
            end else if (i_cmd.pay_load_dig) begin
                r_pay <= 64'(DIGEST_BYTES);
            end else if (i_cmd.pay_load_ext) begin
                r_pay <= 64'(extra_bytes(i_byte[4:0]));
            end else if (i_cmd.pay_dec) begin
                r_pay <= r_pay - 64'd1;
            end
            if (i_cmd.pos_inc) begin
                r_pos <= r_pos + PosW'(1);
            end
            if (i_cmd.ver_load) begin
                r_ver <= w_val[31:0];
            end
            if (i_cmd.start_load) begin
                r_start <= r_pos + PosW'(1);
            end
            if (i_cmd.major_load) begin
                r_major <= i_byte[7:5];
            end
            if (i_cmd.push) begin
                r_level <= r_level + LvlW'(1);
            end else if (i_cmd.pop_level) begin
                r_level <= r_level - LvlW'(1);
            end
        end
    end

    // The top count is held in r_top and the counts below it in the stack.
    // Neither has a reset; only counts of open containers are read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= w_push;
            if (r_level != '0) begin
                r_stack[w_wr_idx] <= r_top;
            end
        end else if (i_cmd.pop_dec) begin
            r_top <= r_top - CntW'(1);
        end else if (i_cmd.pop_level) begin
            r_top <= r_stack[w_rd_idx];
        end
    end

    assign o_status.arg_left_zero = (r_left == 4'd0);
    assign o_status.arg_last      = (r_left == 4'd1);
    assign o_status.arg_value     = n_acc;
    assign o_status.pay_zero      = (r_pay == 64'd0);
    assign o_status.pay_one       = (r_pay == 64'd1);
    assign o_status.pos_full      = (r_pos >= PosW'(MAX_MESSAGE_LEN));
    assign o_status.level_zero    = (r_level == '0);
    assign o_status.level_over    = (r_level > LvlW'(MAX_NEST_DEPTH));
    assign o_status.top_le_one    = (r_top <= CntW'(1));
    assign o_status.body_major    = r_major;

    assign o_version = r_ver;
    assign o_offset  = 17'(r_start);
    assign o_length  = 17'(r_pos - r_start);
endmodule

// ----- design/cebl_ctrl.sv -----
// Controller of the envelope locator: phase machine, handshakes and pop sequencer.
// Depends on cebl_pkg; commands cebl_datapath through t_cmd.
module cebl_ctrl #(
    parameter int DIGEST_BYTES = cebl_pkg::DigestBytes
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    input  cebl_pkg::t_status i_status,
    output cebl_pkg::t_cmd    o_cmd,
    input  logic              i_out_stall,
    output logic              o_valid,
    output logic [7:0]        o_echo,
    output logic [1:0]        o_role,
    output logic              o_done,
    output logic              o_ok,
    output logic              o_take_fields,
    output logic              o_clear
);
    import cebl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_POP  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [3:0] r_phase, n_phase;
    logic       r_err, n_err;
    logic       r_last;
    logic [7:0] r_byte;
    logic [1:0] r_role_base;
    logic       r_valid;
    logic [7:0] r_echo;
    logic [1:0] r_role;
    logic       r_done, r_ok;
    logic       w_accept;
    logic       w_load;
    logic [1:0] n_role_base;
    logic       w_go_pop;
    logic       w_hdr_good;
    logic [63:0] w_v;
    logic [4:0] w_ai;
    logic       w_bad_ai;

    assign o_stall  = (r_state != ST_IDLE) || (r_valid && i_out_stall);
    assign w_accept = i_valid && !o_stall;
    assign w_load   = (n_state == ST_IDLE) && (w_accept || r_state != ST_IDLE);
    assign w_ai     = i_data_byte[4:0];
    assign w_bad_ai = (w_ai >= AI_ONE) && (extra_bytes(w_ai) == 4'd0);
    assign w_v      = i_status.arg_left_zero ? 64'(w_ai) : i_status.arg_value;

    always_comb begin
        unique case (r_phase)
            PH_MAP:  w_hdr_good = (w_v == 64'd4);
            PH_K1:   w_hdr_good = (w_v == 64'd1);
            PH_K3:   w_hdr_good = (w_v == 64'd3);
            PH_K2:   w_hdr_good = (w_v == 64'd2);
            PH_VER:  w_hdr_good = (w_v != 64'd0) && (w_v[63:32] == 32'd0);
            PH_K3B:  w_hdr_good = (w_v == 64'd3);
            PH_DLEN: w_hdr_good = (w_v == 64'(DIGEST_BYTES));
            PH_K4:   w_hdr_good = (w_v == 64'd4);
            default: w_hdr_good = 1'b0;
        endcase
    end

    always_comb begin
        logic finish;
        o_cmd       = '0;
        n_state     = r_state;
        n_phase     = r_phase;
        n_err       = r_err;
        n_role_base = ROLE_ERROR;
        w_go_pop    = 1'b0;
        finish      = 1'b0;
        if (r_state == ST_IDLE && w_accept) begin
            if (r_err) begin
                n_role_base = ROLE_ERROR;
            end else if (i_status.pos_full) begin
                n_err = 1'b1;
            end else begin
                o_cmd.pos_inc = 1'b1;
                if (r_phase == PH_DIGEST) begin
                    n_role_base = ROLE_DIGEST;
                    if (!i_status.pay_zero) begin
                        o_cmd.pay_dec = 1'b1;
                    end
                    if (i_status.pay_zero || i_status.pay_one) begin
                        n_phase = PH_K4;
                    end
                end else if (r_phase == PH_BODY) begin
                    n_role_base = ROLE_BODY;
                    if (!i_status.arg_left_zero) begin
                        o_cmd.acc_shift = 1'b1;
                        if (i_status.arg_last) begin
                            priority case (i_status.body_major)
                                MT_UINT, MT_NINT: w_go_pop = 1'b1;
                                MT_BSTR, MT_TSTR: begin
                                    o_cmd.pay_load_arg = 1'b1;
                                    w_go_pop = (i_status.arg_value == 64'd0);
                                end
                                default: begin
                                    if (i_status.body_major != MT_TAG
                                        && i_status.arg_value == 64'd0) begin
                                        w_go_pop = 1'b1;
                                    end else if (i_status.level_over) begin
                                        n_err = 1'b1;
                                    end else begin
                                        o_cmd.push = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end else if (!i_status.pay_zero) begin
                        o_cmd.pay_dec = 1'b1;
                        w_go_pop = i_status.pay_one;
                    end else if (i_status.level_over || w_bad_ai) begin
                        n_err = 1'b1;
                    end else if (i_data_byte[7:5] == MT_SIMPLE) begin
                        if (w_ai < AI_ONE) begin
                            w_go_pop = 1'b1;
                        end else begin
                            o_cmd.pay_load_ext = 1'b1;
                        end
                    end else begin
                        o_cmd.major_load = 1'b1;
                        if (w_ai >= AI_ONE) begin
                            o_cmd.acc_load = 1'b1;
                        end else begin
                            priority case (i_data_byte[7:5])
                                MT_UINT, MT_NINT: w_go_pop = 1'b1;
                                MT_BSTR, MT_TSTR: begin
                                    o_cmd.pay_load_arg = 1'b1;
                                    w_go_pop = (w_ai == 5'd0);
                                end
                                default: begin
                                    if (i_data_byte[7:5] != MT_TAG && w_ai == 5'd0) begin
                                        w_go_pop = 1'b1;
                                    end else begin
                                        o_cmd.push = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                end else if (r_phase < PH_BODY) begin
                    n_role_base = ROLE_HEADER;
                    if (i_status.arg_left_zero) begin
                        if (i_data_byte[7:5] != want_major(r_phase) || w_bad_ai) begin
                            n_err = 1'b1;
                        end else if (w_ai < AI_ONE) begin
                            finish = 1'b1;
                        end else begin
                            o_cmd.acc_load = 1'b1;
                        end
                    end else begin
                        o_cmd.acc_shift = 1'b1;
                        finish = i_status.arg_last;
                    end
                    if (finish) begin
                        if (!w_hdr_good) begin
                            n_err = 1'b1;
                        end else begin
                            n_phase = r_phase + 4'd1;
                            o_cmd.ver_load     = (r_phase == PH_VER);
                            o_cmd.pay_load_dig = (r_phase == PH_DLEN);
                            o_cmd.start_load   = (r_phase == PH_K4);
                        end
                    end
                end else begin
                    n_err = 1'b1;
                end
            end
            if (w_go_pop) begin
                n_state = ST_POP;
            end else if (i_last_byte) begin
                n_state = ST_FIN;
            end
        end else if (r_state == ST_POP) begin
            // One value finished: walk up the count stack one level a cycle.
            if (i_status.level_zero) begin
                n_phase = PH_DONE;
                n_state = r_last ? ST_FIN : ST_IDLE;
            end else if (i_status.level_over) begin
                n_err   = 1'b1;
                n_state = r_last ? ST_FIN : ST_IDLE;
            end else if (i_status.top_le_one) begin
                o_cmd.pop_level = 1'b1;
            end else begin
                o_cmd.pop_dec = 1'b1;
                n_state = r_last ? ST_FIN : ST_IDLE;
            end
        end else if (r_state == ST_FIN) begin
            o_cmd.clear = 1'b1;
            n_state = ST_IDLE;
            n_phase = PH_MAP;
            n_err   = 1'b0;
        end
    end

    assign o_take_fields = (r_state == ST_FIN);
    assign o_clear = o_cmd.clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_MAP;
            r_err   <= 1'b0;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_err   <= n_err;
            r_valid <= w_load || (r_valid && i_out_stall);
            if (w_accept) begin
                r_last <= i_last_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte      <= i_data_byte;
            r_role_base <= n_err ? ROLE_ERROR : n_role_base;
        end
        if (w_load) begin
            r_echo <= w_accept ? i_data_byte : r_byte;
            r_role <= n_err ? ROLE_ERROR : (w_accept ? n_role_base : r_role_base);
            r_done <= w_accept ? i_last_byte : r_last;
            r_ok   <= (w_accept ? i_last_byte : r_last) && !n_err
                      && (r_state == ST_FIN ? (!r_err && r_phase == PH_DONE)
                                            : (n_phase == PH_DONE));
        end
    end

    assign o_valid = r_valid;
    assign o_echo  = r_echo;
    assign o_role  = r_role;
    assign o_done  = r_done;
    assign o_ok    = r_ok;

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !w_accept) else $error("byte taken while busy");
    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_phase == PH_MAP && !r_err))
        else $error("envelope state not cleared");
    a_ok_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ok) |-> r_done) else $error("ok without done");
    a_err_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_done && r_ok) |-> (r_role == ROLE_BODY))
        else $error("good envelope ended off the body");
`endif
endmodule

// ----- design/cbor_envelope_body_locator_core.sv -----
// Top level of the CBOR envelope body locator.
// Depends on cebl_pkg, cebl_ctrl and cebl_datapath.
// A plain byte causes no stall and its word sits in the output register
// from the next cycle, so such bytes can follow back to back while the output
// is not stalled. A byte that completes a value holds the input while ST_POP
// walks the levels it closes; a final byte also passes ST_FIN to clear state.
// The walk up the pending-count stack sets the worst case. Verdict fields are
// nonzero only on the final word of a good envelope.
module cbor_envelope_body_locator_core #(
    parameter int MAX_MESSAGE_LEN = cebl_pkg::MaxMessageLen,
    parameter int MAX_NEST_DEPTH  = cebl_pkg::MaxNestDepth,
    parameter int DIGEST_BYTES    = cebl_pkg::DigestBytes
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_byte_role,
    output logic [7:0]  o_echo_byte,
    output logic        o_envelope_done,
    output logic        o_envelope_ok,
    output logic [31:0] o_envelope_version,
    output logic [16:0] o_body_offset,
    output logic [16:0] o_body_length
);
    import cebl_pkg::*;

    t_cmd        w_cmd;
    t_status     w_status;
    logic [31:0] w_ver;
    logic [16:0] w_off, w_len;
    logic        w_take, w_clear;
    logic [31:0] r_ver;
    logic [16:0] r_off, r_len;
    logic        w_ok;

    cebl_ctrl #(
        .DIGEST_BYTES (DIGEST_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_status      (w_status),
        .o_cmd         (w_cmd),
        .i_out_stall   (i_stall),
        .o_valid       (o_valid),
        .o_echo        (o_echo_byte),
        .o_role        (o_byte_role),
        .o_done        (o_envelope_done),
        .o_ok          (w_ok),
        .o_take_fields (w_take),
        .o_clear       (w_clear)
    );

    cebl_datapath #(
        .MAX_MESSAGE_LEN (MAX_MESSAGE_LEN),
        .MAX_NEST_DEPTH  (MAX_NEST_DEPTH),
        .DIGEST_BYTES    (DIGEST_BYTES)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_data_byte),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_version (w_ver),
        .o_offset  (w_off),
        .o_length  (w_len)
    );

    always_ff @(posedge i_clk) begin
        if (w_take && w_clear) begin
            r_ver <= w_ver;
            r_off <= w_off;
            r_len <= w_len;
        end
    end

    assign o_envelope_ok      = w_ok;
    assign o_envelope_version = w_ok ? r_ver : 32'd0;
    assign o_body_offset      = w_ok ? r_off : 17'd0;
    assign o_body_length      = w_ok ? r_len : 17'd0;
endmodule
